// ===== sv/assert_macros.svh =====
// Assertion macros shared by the page replacement RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that a property holds at every rising clock edge outside reset.
`define MFU_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed: lbl");
// Checks that a condition is never true outside reset.
`define MFU_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("forbidden condition: lbl");
`else
`define MFU_ASSERT(lbl, clk, rst_n, prop)
`define MFU_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== sv/mfu_pkg.sv =====
// Types, constants and defaults shared by the page replacement block.
package mfu_pkg;

	localparam int FRAMES_DEF     = 8;
	localparam int PAGE_BITS_DEF  = 16;
	localparam int COUNT_BITS_DEF = 16;

	localparam int CFG_W       = 4;
	localparam int PAGE_FIELD_W  = 16;
	localparam int INDEX_FIELD_W = 3;
	localparam int FAULT_W       = 32;

	localparam logic [CFG_W-1:0] FIU_RESET = 4'd8;

	localparam logic MODE_REF   = 1'b0;
	localparam logic MODE_CLEAR = 1'b1;

	typedef struct packed {
		logic                    mode;
		logic [PAGE_FIELD_W-1:0] page_number;
	} req_t;

	typedef struct packed {
		logic                     hit;
		logic [INDEX_FIELD_W-1:0] frame_index;
		logic                     evicted_valid;
		logic [PAGE_FIELD_W-1:0]  evicted_page;
		logic [FAULT_W-1:0]       fault_total;
	} rsp_t;

	// Control part of the search state that walks down the row of frames.
	typedef struct packed {
		logic token;
		logic found;
		logic free_found;
		logic max_have;
	} scan_flags_t;

	// Update broadcast to all frames when a request completes.
	typedef struct packed {
		logic en;
		logic clear;
		logic hit;
	} commit_t;

endpackage

// ===== sv/mfu_cell.sv =====
// One frame of the table together with its stage of the search chain.
module mfu_cell import mfu_pkg::*; #(
	parameter int IDX        = 0,
	parameter int FRAMES     = FRAMES_DEF,
	parameter int PAGE_BITS  = PAGE_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1,
	localparam int NW = $clog2(FRAMES + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [NW-1:0]         n_active,
	input  logic [PAGE_BITS-1:0]  req_page,
	input  scan_flags_t           flags_in,
	input  logic [IW-1:0]         hit_slot_in,
	input  logic [IW-1:0]         free_slot_in,
	input  logic [IW-1:0]         max_slot_in,
	input  logic [COUNT_BITS-1:0] max_count_in,
	input  logic [PAGE_BITS-1:0]  max_page_in,
	output scan_flags_t           flags_out,
	output logic [IW-1:0]         hit_slot_out,
	output logic [IW-1:0]         free_slot_out,
	output logic [IW-1:0]         max_slot_out,
	output logic [COUNT_BITS-1:0] max_count_out,
	output logic [PAGE_BITS-1:0]  max_page_out,
	input  commit_t               commit,
	input  logic [IW-1:0]         commit_slot
);

	localparam logic [IW-1:0]         MY_IDX    = IW'(IDX);
	localparam logic [NW-1:0]         MY_POS    = NW'(IDX);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

	logic                  valid_q;
	logic [PAGE_BITS-1:0]  page_q;
	logic [COUNT_BITS-1:0] count_q;

	scan_flags_t           flags_q;
	logic [IW-1:0]         hit_slot_q;
	logic [IW-1:0]         free_slot_q;
	logic [IW-1:0]         max_slot_q;
	logic [COUNT_BITS-1:0] max_count_q;
	logic [PAGE_BITS-1:0]  max_page_q;

	logic                  active;
	scan_flags_t           flags_d;
	logic [IW-1:0]         hit_slot_d;
	logic [IW-1:0]         free_slot_d;
	logic [IW-1:0]         max_slot_d;
	logic [COUNT_BITS-1:0] max_count_d;
	logic [PAGE_BITS-1:0]  max_page_d;

	assign active = (MY_POS < n_active);

	// The hit and free fields are taken only by the first frame that qualifies, and the max
	// field only on a strictly larger count, which keeps the lowest-index priority of the search.
	always_comb begin
		flags_d     = flags_in;
		hit_slot_d  = hit_slot_in;
		free_slot_d = free_slot_in;
		max_slot_d  = max_slot_in;
		max_count_d = max_count_in;
		max_page_d  = max_page_in;
		if (active && valid_q && (page_q == req_page) && !flags_in.found) begin
			flags_d.found = 1'b1;
			hit_slot_d    = MY_IDX;
		end
		if (active && !valid_q && !flags_in.free_found) begin
			flags_d.free_found = 1'b1;
			free_slot_d        = MY_IDX;
		end
		if (active && (!flags_in.max_have || (count_q > max_count_in))) begin
			flags_d.max_have = 1'b1;
			max_slot_d       = MY_IDX;
			max_count_d      = count_q;
			max_page_d       = page_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else begin
			flags_q <= flags_d;
		end
	end

	always_ff @(posedge clk) begin
		hit_slot_q  <= hit_slot_d;
		free_slot_q <= free_slot_d;
		max_slot_q  <= max_slot_d;
		max_count_q <= max_count_d;
		max_page_q  <= max_page_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			page_q  <= '0;
			count_q <= '0;
		end else if (commit.en && commit.clear) begin
			valid_q <= 1'b0;
			page_q  <= '0;
			count_q <= '0;
		end else if (commit.en && (commit_slot == MY_IDX)) begin
			if (commit.hit) begin
				if (count_q != COUNT_MAX) begin
					count_q <= count_q + COUNT_ONE;
				end
			end else begin
				valid_q <= 1'b1;
				page_q  <= req_page;
				count_q <= COUNT_ONE;
			end
		end
	end

	assign flags_out     = flags_q;
	assign hit_slot_out  = hit_slot_q;
	assign free_slot_out = free_slot_q;
	assign max_slot_out  = max_slot_q;
	assign max_count_out = max_count_q;
	assign max_page_out  = max_page_q;

endmodule

// ===== sv/mfu_page_replacement_core.sv =====
// Top level of the most-frequently-used page replacement table.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------
//  request  | in_valid / in_stall       | in_data  (req_t)
//  result   | out_valid / out_stall     | out_data (rsp_t)
//  config   | cfg_we                    | cfg_wdata (frames in use)
//
// After a request is accepted the search token walks the row of cells, one register per cell,
// the final search state is registered, and the table update loads the result register.
// in_stall stays high until that update, so a new request is taken only after the previous
// one has updated the table. A result held under out_stall delays the update and so also
// holds off the next request.
// Reset empties all frames, zeroes the fault counter and sets frames in use to 8.
`include "assert_macros.svh"
module mfu_page_replacement_core import mfu_pkg::*; #(
	parameter int FRAMES     = FRAMES_DEF,
	parameter int PAGE_BITS  = PAGE_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  req_t             in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output rsp_t             out_data
);

	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int NW = $clog2(FRAMES + 1);
	localparam int CW = (NW > CFG_W) ? NW : CFG_W;
	localparam logic [CW-1:0]      FRAMES_CW = CW'(FRAMES);
	localparam logic [FAULT_W-1:0] FAULT_MAX = '1;
	localparam logic [FAULT_W-1:0] FAULT_ONE = FAULT_W'(1);

	logic [CFG_W-1:0]     fiu_q;
	logic                 busy_q;
	logic                 start_q;
	logic                 clear_q;
	logic [PAGE_BITS-1:0] page_q;
	logic [FAULT_W-1:0]   fault_q;

	logic                 done_q;
	logic                 found_q;
	logic                 free_found_q;
	logic [IW-1:0]        hit_slot_q;
	logic [IW-1:0]        free_slot_q;
	logic [IW-1:0]        max_slot_q;
	logic [PAGE_BITS-1:0] max_page_q;

	logic                 out_valid_q;
	rsp_t                 out_data_q;

	logic [CW-1:0]        fiu_cw;
	logic [CW-1:0]        n_cw;
	logic [NW-1:0]        n_active;
	logic                 accept;
	logic                 commit;
	logic [IW-1:0]        slot;
	logic [FAULT_W-1:0]   fault_next;
	logic [PAGE_BITS+PAGE_FIELD_W-1:0] page_ext;
	logic [PAGE_BITS+PAGE_FIELD_W-1:0] evict_ext;
	logic [IW+INDEX_FIELD_W-1:0]       index_ext;
	commit_t              commit_bus;

	scan_flags_t           flags_c     [FRAMES+1];
	logic [IW-1:0]         hit_slot_c  [FRAMES+1];
	logic [IW-1:0]         free_slot_c [FRAMES+1];
	logic [IW-1:0]         max_slot_c  [FRAMES+1];
	logic [COUNT_BITS-1:0] max_count_c [FRAMES+1];
	logic [PAGE_BITS-1:0]  max_page_c  [FRAMES+1];
	logic [FRAMES-1:0]     tokens;

	// Frames in use of zero acts as one; values beyond the table saturate.
	assign fiu_cw   = CW'(fiu_q);
	assign n_cw     = (fiu_cw == '0) ? CW'(1) : ((fiu_cw > FRAMES_CW) ? FRAMES_CW : fiu_cw);
	assign n_active = n_cw[NW-1:0];

	assign accept   = in_valid && !busy_q;
	assign in_stall = busy_q;
	assign commit   = done_q && (!out_valid_q || !out_stall);

	assign page_ext = {{PAGE_BITS{1'b0}}, in_data.page_number};

	assign flags_c[0]     = '{token: start_q, found: 1'b0, free_found: 1'b0, max_have: 1'b0};
	assign hit_slot_c[0]  = '0;
	assign free_slot_c[0] = '0;
	assign max_slot_c[0]  = '0;
	assign max_count_c[0] = '0;
	assign max_page_c[0]  = '0;

	generate
		for (genvar g = 0; g < FRAMES; g++) begin : g_cell
			mfu_cell #(
				.IDX        (g),
				.FRAMES     (FRAMES),
				.PAGE_BITS  (PAGE_BITS),
				.COUNT_BITS (COUNT_BITS)
			) u_cell (
				.clk           (clk),
				.arst_n        (arst_n),
				.n_active      (n_active),
				.req_page      (page_q),
				.flags_in      (flags_c[g]),
				.hit_slot_in   (hit_slot_c[g]),
				.free_slot_in  (free_slot_c[g]),
				.max_slot_in   (max_slot_c[g]),
				.max_count_in  (max_count_c[g]),
				.max_page_in   (max_page_c[g]),
				.flags_out     (flags_c[g+1]),
				.hit_slot_out  (hit_slot_c[g+1]),
				.free_slot_out (free_slot_c[g+1]),
				.max_slot_out  (max_slot_c[g+1]),
				.max_count_out (max_count_c[g+1]),
				.max_page_out  (max_page_c[g+1]),
				.commit        (commit_bus),
				.commit_slot   (slot)
			);
			assign tokens[g] = flags_c[g+1].token;
		end
	endgenerate

	// A miss fills the lowest free frame, or else evicts the busiest one.
	assign slot = found_q ? hit_slot_q : (free_found_q ? free_slot_q : max_slot_q);

	assign commit_bus = '{en: commit, clear: clear_q, hit: found_q};

	always_comb begin
		fault_next = fault_q;
		if (clear_q) begin
			fault_next = '0;
		end else if (!found_q && (fault_q != FAULT_MAX)) begin
			fault_next = fault_q + FAULT_ONE;
		end
	end

	assign evict_ext = {{PAGE_FIELD_W{1'b0}}, max_page_q};
	assign index_ext = {{INDEX_FIELD_W{1'b0}}, slot};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q <= FIU_RESET;
		end else if (cfg_we) begin
			fiu_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			start_q     <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
			fault_q     <= '0;
		end else begin
			start_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (flags_c[FRAMES].token) begin
				done_q <= 1'b1;
			end else if (commit) begin
				done_q <= 1'b0;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
				fault_q     <= fault_next;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			clear_q <= (in_data.mode == MODE_CLEAR);
			page_q  <= page_ext[PAGE_BITS-1:0];
		end
		if (flags_c[FRAMES].token) begin
			found_q      <= flags_c[FRAMES].found;
			free_found_q <= flags_c[FRAMES].free_found;
			hit_slot_q   <= hit_slot_c[FRAMES];
			free_slot_q  <= free_slot_c[FRAMES];
			max_slot_q   <= max_slot_c[FRAMES];
			max_page_q   <= max_page_c[FRAMES];
		end
		if (commit) begin
			if (clear_q) begin
				out_data_q <= '0;
			end else begin
				out_data_q.hit           <= found_q;
				out_data_q.frame_index   <= index_ext[INDEX_FIELD_W-1:0];
				out_data_q.evicted_valid <= !found_q && !free_found_q;
				out_data_q.evicted_page  <= (!found_q && !free_found_q) ?
					evict_ext[PAGE_FIELD_W-1:0] : '0;
				out_data_q.fault_total   <= fault_next;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`MFU_NEVER(a_single_token, clk, arst_n, !$onehot0({tokens, start_q, done_q}))
	`MFU_NEVER(a_idle_no_search, clk, arst_n, !busy_q && (start_q || done_q || (tokens != '0)))
	`MFU_ASSERT(a_accept_launches, clk, arst_n, accept |=> (start_q && busy_q))
	`MFU_ASSERT(a_commit_shows, clk, arst_n, commit |=> (out_valid_q && !busy_q))
	`MFU_ASSERT(a_fault_monotone, clk, arst_n,
		(commit && !clear_q) |=> (fault_q >= $past(fault_q)))

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the most-frequently-used page replacement core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mfu_pkg::*;

	localparam int TABLE_FRAMES = FRAMES_DEF;
	localparam logic [COUNT_BITS_DEF-1:0] USE_COUNT_MAX = '1;
	localparam logic [FAULT_W-1:0] FAULT_COUNT_MAX = '1;
	localparam int DIRECTED_ROWS = 22;
	localparam int RANDOM_PER_PHASE = 540;
	localparam int CONFIG_EVERY = 110;
	localparam int HOT_HITS = 20;
	localparam int DRAIN_CYCLES = 4 * (TABLE_FRAMES + 2);
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic             set_cfg;
		logic [CFG_W-1:0] cfg_value;
		req_t             req;
		logic             known;
		rsp_t             fixed;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rsp_t out_data;

	// Shadow copy of the frame table and the frames-in-use register.
	logic                      resident [TABLE_FRAMES] = '{default: 1'b0};
	logic [PAGE_FIELD_W-1:0]   resident_page [TABLE_FRAMES] = '{default: '0};
	logic [COUNT_BITS_DEF-1:0] use_count [TABLE_FRAMES] = '{default: '0};
	logic [FAULT_W-1:0]        fault_count = '0;
	logic [CFG_W-1:0]          frames_in_use = FIU_RESET;

	rsp_t expected_results [$];
	int mismatches = 0;
	int quiet_cycles = 0;
	int sender_idle_pct = 0;
	int receiver_idle_pct = 0;
	directed_row_t directed_rows [DIRECTED_ROWS];

	mfu_page_replacement_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #1 clk = ~clk;

	// Applies one request to the shadow table and returns the result it causes.
	function automatic rsp_t apply_reference(input req_t req);
		rsp_t res;
		int active;
		int slot;
		bit found;
		bit free_found;
		res = '0;
		if (req.mode == MODE_CLEAR) begin
			for (int i = 0; i < TABLE_FRAMES; i++) begin
				resident[i] = 1'b0;
				resident_page[i] = '0;
				use_count[i] = '0;
			end
			fault_count = '0;
			return res;
		end
		if (frames_in_use == 0)
			active = 1;
		else if (frames_in_use > TABLE_FRAMES)
			active = TABLE_FRAMES;
		else
			active = int'(frames_in_use);
		slot = 0;
		found = 1'b0;
		for (int i = 0; i < active; i++) begin
			if (!found && resident[i] && resident_page[i] == req.page_number) begin
				slot = i;
				found = 1'b1;
			end
		end
		if (found) begin
			res.hit = 1'b1;
			if (use_count[slot] != USE_COUNT_MAX)
				use_count[slot] = use_count[slot] + 1'b1;
		end else begin
			if (fault_count != FAULT_COUNT_MAX)
				fault_count = fault_count + 1'b1;
			free_found = 1'b0;
			for (int i = 0; i < active; i++) begin
				if (!free_found && !resident[i]) begin
					slot = i;
					free_found = 1'b1;
				end
			end
			// Table full: the lowest frame with the highest use count goes.
			if (!free_found) begin
				slot = 0;
				for (int i = 1; i < active; i++)
					if (use_count[i] > use_count[slot])
						slot = i;
				res.evicted_valid = 1'b1;
				res.evicted_page = resident_page[slot];
			end
			resident[slot] = 1'b1;
			resident_page[slot] = req.page_number;
			use_count[slot] = COUNT_BITS_DEF'(1);
		end
		res.frame_index = INDEX_FIELD_W'(slot);
		res.fault_total = fault_count;
		return res;
	endfunction

	task automatic note_mismatch(input string what, input rsp_t want, input rsp_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t %s: expected hit=%0d frame=%0d evicted=%0d/%h faults=%0d, got hit=%0d frame=%0d evicted=%0d/%h faults=%0d",
				$realtime, what, want.hit, want.frame_index, want.evicted_valid,
				want.evicted_page, want.fault_total, got.hit, got.frame_index,
				got.evicted_valid, got.evicted_page, got.fault_total);
	endtask

	task automatic send_request(input req_t req, input logic known, input rsp_t fixed);
		rsp_t predicted;
		while ($urandom_range(99) < sender_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= req;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		predicted = apply_reference(req);
		expected_results.push_back(known ? fixed : predicted);
	endtask

	// The sender holds off until every result is back before the register changes.
	task automatic write_frames_in_use(input logic [CFG_W-1:0] value);
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		frames_in_use = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(negedge clk)
		out_stall <= arst_n && ($urandom_range(99) < receiver_idle_pct);

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (expected_results.size() == 0) begin
				note_mismatch("unexpected result", '0, out_data);
			end else begin
				want = expected_results.pop_front();
				if (out_data.hit !== want.hit || out_data.frame_index !== want.frame_index
						|| out_data.evicted_valid !== want.evicted_valid
						|| out_data.evicted_page !== want.evicted_page
						|| out_data.fault_total !== want.fault_total)
					note_mismatch("result mismatch", want, out_data);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("mfu_page_replacement_core: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		req_t req;
		int roll;
		int pool_span;
		logic [PAGE_FIELD_W-1:0] page_pool [16];

		// Rows: set_cfg, cfg_value, request, known, fixed result.
		directed_rows = '{
			'{1'b0, 4'd0,  '{MODE_REF,   16'h0000}, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 32'd1}},
			'{1'b0, 4'd0,  '{MODE_REF,   16'hFFFF}, 1'b1, '{1'b0, 3'd1, 1'b0, 16'h0000, 32'd2}},
			'{1'b0, 4'd0,  '{MODE_REF,   16'h0000}, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 32'd2}},
			'{1'b0, 4'd0,  '{MODE_CLEAR, 16'hFFFF}, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 32'd0}},
			'{1'b1, 4'd1,  '{MODE_REF,   16'h1234}, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 32'd1}},
			'{1'b0, 4'd0,  '{MODE_REF,   16'h5678}, 1'b1, '{1'b0, 3'd0, 1'b1, 16'h1234, 32'd2}},
			'{1'b0, 4'd0,  '{MODE_REF,   16'h5678}, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 32'd2}},
			// Zero frames in use behaves as one frame.
			'{1'b1, 4'd0,  '{MODE_REF,   16'hAAAA}, 1'b1, '{1'b0, 3'd0, 1'b1, 16'h5678, 32'd3}},
			// Values above the table size saturate to the full table.
			'{1'b1, 4'd15, '{MODE_REF,   16'hAAAA}, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 32'd3}},
			'{1'b0, 4'd0,  '{MODE_REF,   16'h5555}, 1'b1, '{1'b0, 3'd1, 1'b0, 16'h0000, 32'd4}},
			'{1'b0, 4'd0,  '{MODE_REF,   16'h0001}, 1'b0, '0},
			'{1'b0, 4'd0,  '{MODE_REF,   16'h0002}, 1'b0, '0},
			'{1'b0, 4'd0,  '{MODE_REF,   16'h0003}, 1'b0, '0},
			'{1'b0, 4'd0,  '{MODE_REF,   16'h0004}, 1'b0, '0},
			'{1'b0, 4'd0,  '{MODE_REF,   16'h0005}, 1'b0, '0},
			'{1'b0, 4'd0,  '{MODE_REF,   16'h0006}, 1'b0, '0},
			'{1'b0, 4'd0,  '{MODE_REF,   16'h5555}, 1'b0, '0},
			'{1'b0, 4'd0,  '{MODE_REF,   16'h5555}, 1'b0, '0},
			'{1'b0, 4'd0,  '{MODE_REF,   16'h00FF}, 1'b0, '0},
			// Shrinking then growing the table leaves page 3 in two frames.
			'{1'b1, 4'd2,  '{MODE_REF,   16'h0003}, 1'b0, '0},
			'{1'b1, 4'd8,  '{MODE_REF,   16'h0003}, 1'b0, '0},
			'{1'b0, 4'd0,  '{MODE_CLEAR, 16'h0000}, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 32'd0}}
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r]) begin
			if (directed_rows[r].set_cfg)
				write_frames_in_use(directed_rows[r].cfg_value);
			send_request(directed_rows[r].req, directed_rows[r].known, directed_rows[r].fixed);
		end

		// One page is hit many times, then it must be the victim.
		write_frames_in_use(4'd2);
		req.mode = MODE_REF;
		req.page_number = 16'hC0DE;
		for (int n = 0; n <= HOT_HITS; n++)
			send_request(req, 1'b0, '0);
		req.page_number = 16'hBEEF;
		send_request(req, 1'b0, '0);
		req.page_number = 16'h0F0F;
		send_request(req, 1'b0, '0);

		for (int phase = 0; phase < 3; phase++) begin
			sender_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 52 : 0;
			receiver_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 33 : 0;
			for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
				if (k % CONFIG_EVERY == 0) begin
					write_frames_in_use(CFG_W'($urandom_range(15)));
					pool_span = $urandom_range(4, 16);
					foreach (page_pool[j])
						page_pool[j] = PAGE_FIELD_W'($urandom);
				end
				// Mostly a small working set so hits and evictions both occur.
				roll = $urandom_range(99);
				req.mode = (roll < 2) ? MODE_CLEAR : MODE_REF;
				req.page_number = (roll < 12) ? PAGE_FIELD_W'($urandom)
					: page_pool[$urandom_range(pool_span - 1)];
				send_request(req, 1'b0, '0);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("mfu_page_replacement_core: match");
		else
			$display("mfu_page_replacement_core: mismatch");
		$finish;
	end

endmodule
